// ===== hdl/mcr_pkg.sv =====
// Package for the midpoint circle rasteriser: field widths, register
// indexes and the step record passed from front to back.
// No dependencies.
package mcr_pkg;

   localparam int RADIUS_BITS   = 10;
   localparam int WALK_Y_BITS   = 11;
   localparam int DEC_BITS      = 13;
   localparam int CSR_DATA_BITS = 16;
   localparam int CALC_BITS     = 18;
   localparam int REQ_DATA_BITS = 8;

   localparam logic [1:0] CSR_RADIUS   = 2'd0;
   localparam logic [1:0] CSR_CENTER_X = 2'd1;
   localparam logic [1:0] CSR_CENTER_Y = 2'd2;

   localparam logic [2:0] LAST_POINT = 3'd7;

   typedef struct packed {
      logic [RADIUS_BITS-1:0] x;
      logic [WALK_Y_BITS-1:0] y;
      logic                   finished;
   } step_type;

endpackage

// ===== hdl/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasteriser, top level: configuration registers, front end,
// step queue and point back end. Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
// First point of a step: the request is written into the queue, then the back end
// loads it into the point output register, with the back end idle.
// Output: eight points per step at one per cycle while rsp_tready is high,
// set by the single result port; a request that emits nothing posts no step record.
// Reset: synchronous; clears registers, walk state, queue and output valid.
module midpoint_circle_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: [0] restart
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [mcr_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   // rsp_tdata: point_x, point_y from bit 0 up; zero padded to bytes
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0]  rsp_tdata,
   output logic                                   rsp_tlast,
   // rsp_tuser: [0] circle_done
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [mcr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import mcr_pkg::*;

   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [COORD_BITS-1:0]  center_x_ff, center_x_in, center_y_ff, center_y_in;

   logic                push, push_ready, head_valid, pop;
   step_type            push_data, head;
   logic [COORD_BITS:0] point_x, point_y;

   always_comb begin
      csr_ready   = 1'b1;
      radius_in   = radius_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:   radius_in   = csr_wdata[RADIUS_BITS-1:0];
            CSR_CENTER_X: center_x_in = csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Y: center_y_in = csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else begin
         radius_ff   <= radius_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   mcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .restart    (req_tdata[0]),
      .radius     (radius_ff),
      .push       (push),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head       (head)
   );

   mcr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .point_x      (point_x),
      .point_y      (point_y),
      .last_of_step (rsp_tlast),
      .circle_done  (rsp_tuser)
   );

   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[COORD_BITS:0]                = point_x;
      rsp_tdata[2*COORD_BITS+1:COORD_BITS+1] = point_y;
   end

endmodule

// ===== hdl/mcr_front.sv =====
// Front end: accepts step requests, walks the octant (x, y, decision)
// and posts one step record per emitting step. Depends on mcr_pkg.
module mcr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             restart,
   input  logic [mcr_pkg::RADIUS_BITS-1:0]  radius,
   output logic                             push,
   input  logic                             push_ready,
   output mcr_pkg::step_type                push_data
);
   import mcr_pkg::*;

   logic [RADIUS_BITS-1:0]    walk_x_ff, walk_x_in;
   logic [WALK_Y_BITS-1:0]    walk_y_ff, walk_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic                      active_ff, active_in;

   logic                      accept, act;
   logic [RADIUS_BITS-1:0]    x0;
   logic [WALK_Y_BITS-1:0]    y0;
   logic signed [DEC_BITS-1:0] d0, xw, ny, nx, diff, np;
   logic                      go_down, finished;

   always_comb begin
      accept    = req_valid && push_ready;
      req_ready = push_ready;
      act       = restart || active_ff;
      x0        = restart ? radius : walk_x_ff;
      y0        = restart ? '0 : walk_y_ff;
      d0        = restart ? (DEC_BITS'(1) - DEC_BITS'(radius)) : decision_ff;
      xw        = DEC_BITS'(x0);
      ny        = DEC_BITS'(y0) + DEC_BITS'(1);
      go_down   = d0 > 0;
      nx        = go_down ? xw - DEC_BITS'(1) : xw;
      diff      = go_down ? ny - nx : ny;
      np        = d0 + (diff <<< 1) + DEC_BITS'(1);
      finished  = nx < ny;

      push             = accept && act;
      push_data.x      = x0;
      push_data.y      = y0;
      push_data.finished = finished;

      walk_x_in   = walk_x_ff;
      walk_y_in   = walk_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      if (push) begin
         if (finished) begin
            walk_x_in   = '0;
            walk_y_in   = '0;
            decision_in = '0;
            active_in   = 1'b0;
         end else begin
            walk_x_in   = nx[RADIUS_BITS-1:0];
            walk_y_in   = ny[WALK_Y_BITS-1:0];
            decision_in = np;
            active_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff   <= '0;
         walk_y_ff   <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         walk_x_ff   <= walk_x_in;
         walk_y_ff   <= walk_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
      end
   end

   a_finish_ends: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.finished) |=> !active_ff)
      else $error("circle still active after its final step");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (WALK_Y_BITS'(walk_x_ff) >= walk_y_ff))
      else $error("octant walk passed the diagonal");

endmodule

// ===== hdl/mcr_queue.sv =====
// Two-entry queue of step records between front and back end.
// Depends on mcr_pkg.
module mcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              push_ready,
   input  mcr_pkg::step_type push_data,
   output logic              head_valid,
   input  logic              pop,
   output mcr_pkg::step_type head
);
   import mcr_pkg::*;

   step_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      push_ready = count_ff != 2'd2;
      head_valid = count_ff != 2'd0;
      head       = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ===== hdl/mcr_back.sv =====
// Back end: expands each step record into its eight octant points, one
// per cycle unless stalled, into the output register. Depends on mcr_pkg.
module mcr_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  mcr_pkg::step_type            head,
   output logic                         pop,
   input  logic [COORD_BITS-1:0]        center_x,
   input  logic [COORD_BITS-1:0]        center_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COORD_BITS:0]          point_x,
   output logic [COORD_BITS:0]          point_y,
   output logic                         last_of_step,
   output logic                         circle_done
);
   import mcr_pkg::*;

   logic [2:0]           k_ff, k_in;
   logic                 valid_ff, valid_in;
   logic [COORD_BITS:0]  point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic                 last_ff, last_in, done_ff, done_in;

   logic                        load, swap, neg_x, neg_y;
   logic signed [CALC_BITS-1:0] cx_w, cy_w, xw, yw, dx, dy, sum_x, sum_y;

   always_comb begin
      load  = head_valid && (!valid_ff || rsp_ready);
      swap  = k_ff[0] ^ k_ff[1];
      neg_x = k_ff[1] ^ k_ff[2];
      neg_y = k_ff[2];
      cx_w  = CALC_BITS'(signed'(center_x));
      cy_w  = CALC_BITS'(signed'(center_y));
      xw    = CALC_BITS'(head.x);
      yw    = CALC_BITS'(head.y);
      dx    = swap ? yw : xw;
      dy    = swap ? xw : yw;
      sum_x = neg_x ? cx_w - dx : cx_w + dx;
      sum_y = neg_y ? cy_w - dy : cy_w + dy;

      pop        = load && (k_ff == LAST_POINT);
      k_in       = k_ff;
      valid_in   = valid_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      if (load) begin
         k_in       = k_ff + 3'd1;
         valid_in   = 1'b1;
         point_x_in = sum_x[COORD_BITS:0];
         point_y_in = sum_y[COORD_BITS:0];
         last_in    = k_ff == LAST_POINT;
         done_in    = (k_ff == LAST_POINT) && head.finished;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end

      rsp_valid    = valid_ff;
      point_x      = point_x_ff;
      point_y      = point_y_ff;
      last_of_step = last_ff;
      circle_done  = done_ff;
   end

   always_ff @(posedge clock) begin
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && circle_done) |-> last_of_step)
      else $error("circle end flagged off a step boundary");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      load |=> (last_ff == ($past(k_ff) == LAST_POINT)))
      else $error("step end out of line with point counter");

endmodule

// ===== test/tb_top.sv =====
// Testbench for midpoint_circle_rasterizer: directed table then random circles,
// every point checked against an in-bench midpoint circle walker or a typed row's fixed value.
// Depends on mcr_pkg and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcr_pkg::*;

   localparam int COORD_BITS  = 12;
   localparam int PT_BITS     = COORD_BITS + 1;
   localparam int RSP_BITS    = ((2 * PT_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_STEPS = 125;
   localparam int MAX_WALK    = 40;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [PT_BITS-1:0] px;
      logic [PT_BITS-1:0] py;
      logic               last;
      logic               done;
   } point_type;

   typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [1:0]         idx;
      logic [15:0]        data;
      logic               restart;
      logic               typed;
      logic [3:0]         t_count;
      logic [PT_BITS-1:0] t_x;
      logic [PT_BITS-1:0] t_y;
      logic               t_done;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // circle walker state and register shadow
   logic [RADIUS_BITS-1:0]       cfg_radius = '0;
   logic signed [COORD_BITS-1:0] cfg_cx = '0;
   logic signed [COORD_BITS-1:0] cfg_cy = '0;
   int  walk_x = 0;
   int  walk_y = 0;
   int  decision = 0;
   bit  walking = 1'b0;

   point_type step_points[$];
   point_type expected_points[$];
   int     error_count = 0;
   int     cycle_count = 0;
   bit     send_idle = 1'b0;
   bit     recv_stall = 1'b0;
   int     idle_pct = 71;
   int     scored = 0;

   stim_row_type directed_rows [28] = '{
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b1, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b1, 4'd8, 13'h0000, 13'h0000, 1'b1},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b1, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_CENTER_X, 16'h07FF, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_CENTER_Y, 16'h0800, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b1, 4'd8, 13'h07FF, 13'h1800, 1'b1},
      '{ROW_WRITE, CSR_UNUSED,   16'hFFFF, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b1, 4'd8, 13'h07FF, 13'h1800, 1'b1},
      '{ROW_WRITE, CSR_CENTER_X, 16'hF800, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_CENTER_Y, 16'h07FF, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_RADIUS,   16'hFFFF, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_CENTER_X, 16'h0005, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_RADIUS,   16'h0003, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b1, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_RADIUS,   16'h0001, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_WRITE, CSR_CENTER_Y, 16'hF000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b1, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b0, 4'd0, 13'h0000, 13'h0000, 1'b0},
      '{ROW_STEP,  CSR_RADIUS,   16'h0000, 1'b0, 1'b1, 4'd0, 13'h0000, 13'h0000, 1'b0}
   };

   midpoint_circle_rasterizer #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // one midpoint step: eight octant points, then advance the walk
   function automatic void plot_step(input logic restart);
      int cx, cy, nx, ny, np, k;
      int px[8];
      int py[8];
      bit finished;
      logic signed [DEC_BITS-1:0] dec_wrapped;
      point_type pt;
      step_points.delete();
      if (restart) begin
         walk_x   = int'(cfg_radius);
         walk_y   = 0;
         decision = 1 - int'(cfg_radius);
         walking  = 1'b1;
      end
      if (!walking) return;
      cx = cfg_cx;
      cy = cfg_cy;
      px = '{cx + walk_x, cx + walk_y, cx - walk_y, cx - walk_x,
             cx - walk_x, cx - walk_y, cx + walk_y, cx + walk_x};
      py = '{cy + walk_y, cy + walk_x, cy + walk_x, cy + walk_y,
             cy - walk_y, cy - walk_x, cy - walk_x, cy - walk_y};
      ny = walk_y + 1;
      nx = walk_x;
      if (decision <= 0) begin
         np = decision + 2 * ny + 1;
      end else begin
         nx = walk_x - 1;
         np = decision + 2 * (ny - nx) + 1;
      end
      finished = nx < ny;
      if (finished) begin
         walking  = 1'b0;
         walk_x   = 0;
         walk_y   = 0;
         decision = 0;
      end else begin
         walk_x      = nx & ((1 << RADIUS_BITS) - 1);
         walk_y      = ny & ((1 << WALK_Y_BITS) - 1);
         dec_wrapped = np[DEC_BITS-1:0];
         decision    = dec_wrapped;
      end
      for (k = 0; k < 8; k++) begin
         pt.px   = px[k][PT_BITS-1:0];
         pt.py   = py[k][PT_BITS-1:0];
         pt.last = (k == LAST_POINT);
         pt.done = (k == LAST_POINT) && finished;
         step_points.push_back(pt);
      end
   endfunction

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_RADIUS:   cfg_radius = value[RADIUS_BITS-1:0];
         CSR_CENTER_X: cfg_cx = value[COORD_BITS-1:0];
         CSR_CENTER_Y: cfg_cy = value[COORD_BITS-1:0];
         default: ;
      endcase
   endtask

   // typed rows replace the walker's points with a fixed expectation
   task automatic send_step(input logic restart, input logic typed = 1'b0,
                            input logic [3:0] t_count = '0,
                            input logic [PT_BITS-1:0] t_x = '0,
                            input logic [PT_BITS-1:0] t_y = '0,
                            input logic t_done = 1'b0);
      point_type pt;
      if (send_idle && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(restart);
      do @(posedge clock); while (!req_tready);
      plot_step(restart);
      scored++;
      if (typed) begin
         for (int k = 0; k < int'(t_count); k++) begin
            pt.px   = t_x;
            pt.py   = t_y;
            pt.last = (k == LAST_POINT);
            pt.done = (k == LAST_POINT) && t_done;
            expected_points.push_back(pt);
         end
      end else begin
         foreach (step_points[k]) expected_points.push_back(step_points[k]);
      end
   endtask

   always @(posedge clock) begin
      point_type want;
      point_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      rsp_tready <= recv_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.px   = rsp_tdata[PT_BITS-1:0];
         got.py   = rsp_tdata[2*PT_BITS-1:PT_BITS];
         got.last = rsp_tlast;
         got.done = rsp_tuser;
         if (expected_points.size() == 0) begin
            $display("%0t unexpected point x=%0d y=%0d last=%b done=%b", $time,
                     $signed(got.px), $signed(got.py), got.last, got.done);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (got.px !== want.px || got.py !== want.py ||
                got.last !== want.last || got.done !== want.done) begin
               $display({"%0t point mismatch: exp x=%0d y=%0d last=%b done=%b,",
                         " got x=%0d y=%0d last=%b done=%b"},
                        $time, $signed(want.px), $signed(want.py), want.last, want.done,
                        $signed(got.px), $signed(got.py), got.last, got.done);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase;
      stim_row_type row;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE)
            write_reg(row.idx, row.data);
         else
            send_step(row.restart, row.typed, row.t_count, row.t_x, row.t_y, row.t_done);
      end

      scored = 0;
      phase  = 0;
      while (scored < RANDOM_STEPS) begin
         phase++;
         send_idle  = phase[0];
         recv_stall = phase[1];
         idle_pct   = (phase[0] && phase[1]) ? 18 : 71;
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       write_reg(CSR_RADIUS, 16'($urandom_range(0, 65535)));
               1, 2:    write_reg(CSR_RADIUS, {6'($urandom), 10'($urandom_range(11, 60))});
               default: write_reg(CSR_RADIUS, {6'($urandom), 10'($urandom_range(0, 10))});
            endcase
         end
         if ($urandom_range(0, 2) != 0)
            write_reg(CSR_CENTER_X, ($urandom_range(0, 3) == 0) ?
                      {4'($urandom), 1'($urandom), {11{1'($urandom)}}} : 16'($urandom));
         if ($urandom_range(0, 2) != 0)
            write_reg(CSR_CENTER_Y, ($urandom_range(0, 3) == 0) ?
                      {4'($urandom), 1'($urandom), {11{1'($urandom)}}} : 16'($urandom));
         if ($urandom_range(0, 9) == 0)
            write_reg(CSR_UNUSED, 16'($urandom));
         // most phases draw a fresh circle; the rest carry on the old one
         send_step($urandom_range(0, 3) != 0);
         for (int n = 0; walking && n < MAX_WALK; n++)
            send_step($urandom_range(0, 19) == 0);
         repeat ($urandom_range(0, 2)) send_step(1'b0);
      end

      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== midpoint_circle_rasterizer.f =====
hdl/mcr_pkg.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer.sv
test/tb_top.sv
